// ===== rtl/core/cap_pkg.sv =====
// ----------------------------------------------------------------------------
// cap_pkg
// Shared types and constants for the contrast adjustment pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cap_pkg;

  localparam int AMT_W      = 11;    // signed contrast amount
  localparam int NUM_W      = 18;    // dividend width, holds up to 255000
  localparam int DIV_W      = 10;    // divisor width, holds up to 1000
  localparam int Q_W        = 8;     // quotient bits produced by the divider
  localparam int SCALE      = 1000;
  localparam int PIVOT      = 128;
  localparam int AMOUNT_MAX = 1000;

  // Work carried through the divider stages.
  typedef struct packed {
    logic [NUM_W-1:0] rem;     // running remainder, starts as the dividend
    logic [DIV_W-1:0] div;     // divisor
    logic [Q_W-1:0]   quo;     // quotient bits found so far
    logic             sat;     // quotient does not fit in Q_W bits
    logic             pos;     // positive amount: expand away from the pivot
    logic             below;   // sample lies below the pivot
    logic             alpha;   // alpha item, passes through
    logic [7:0]       sample;
  } cap_div_t;

endpackage

`default_nettype wire

// ===== rtl/core/cap_divider.sv =====
// ----------------------------------------------------------------------------
// cap_divider
// Pipelined restoring divider: four stages, two quotient bits per stage,
// with an overflow check in the first stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cap_divider import cap_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire cap_div_t in_data,
  output logic          out_valid,
  output cap_div_t      out_data
);

  localparam int STAGES = Q_W / 2;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] src_vld;
  cap_div_t          stg [STAGES];
  cap_div_t          src [STAGES];
  cap_div_t          nxt [STAGES];

  assign src[0]     = in_data;
  assign src_vld[0] = in_valid;

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      if (s > 0) begin : g_link
        assign src[s]     = stg[s-1];
        assign src_vld[s] = vld[s-1];
      end

      always_comb begin
        logic [NUM_W-1:0] shifted;
        logic [2:0]       bi;
        nxt[s] = src[s];
        // The quotient overflows when the dividend reaches divisor * 2^Q_W.
        if (s == 0) begin
          nxt[s].sat = (src[s].rem >= {src[s].div, {Q_W{1'b0}}});
        end
        for (int j = 0; j < 2; j++) begin
          bi      = 3'(Q_W - 1 - 2 * s - j);
          shifted = NUM_W'(nxt[s].div) << bi;
          if (nxt[s].rem >= shifted) begin
            nxt[s].rem     = nxt[s].rem - shifted;
            nxt[s].quo[bi] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else if (en) begin
          vld[s] <= src_vld[s];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stg[s] <= nxt[s];
        end
      end
    end
  endgenerate

  assign out_valid = vld[STAGES-1];
  assign out_data  = stg[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/contrast_adjust_pixel.sv =====
// Structure: six register stages, the first loaded at the edge that accepts an item.
// Throughput: one item per cycle unless a valid output is stalled; the four-stage
// divider takes two quotient bits per stage and the whole pipeline advances
// whenever the output register is empty or not stalled.
// Reset: rst clears all valid bits and sets the contrast amount to zero.
// ----------------------------------------------------------------------------
// contrast_adjust_pixel
// Linear contrast curve around 128 for 8-bit components, alpha passes.
// ----------------------------------------------------------------------------
`default_nettype none

module contrast_adjust_pixel import cap_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write_en,
  input  wire logic [AMT_W-1:0] cfg_write_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       sample,
  input  wire logic             is_alpha,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            adjusted
);

  logic signed [AMT_W-1:0] amount;
  logic signed [AMT_W-1:0] amount_next;
  logic                    en;

  // Amount register, saturated to the legal range on write.
  always_comb begin
    logic signed [AMT_W-1:0] wr;
    wr = $signed(cfg_write_data);
    if (wr > $signed(AMT_W'(AMOUNT_MAX))) begin
      amount_next = AMT_W'(AMOUNT_MAX);
    end else if (wr < -$signed(AMT_W'(AMOUNT_MAX))) begin
      amount_next = -$signed(AMT_W'(AMOUNT_MAX));
    end else begin
      amount_next = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      amount <= '0;
    end else if (cfg_write_en) begin
      amount <= amount_next;
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: form dividend and divisor. For a non-positive amount the
  // result is (1000*i + k*(128-i)) / 1000; for a positive one it is
  // 128 +/- 1000*|i-128| / (1000-m), sign applied at the end.
  cap_div_t s1_next;
  cap_div_t s1;
  logic     s1_vld;

  always_comb begin
    logic                    pos;
    logic                    below;
    logic signed [AMT_W-1:0] neg_amt;
    logic [DIV_W-1:0]        k;
    logic signed [8:0]       t;
    logic signed [19:0]      prod;
    logic [NUM_W-1:0]        x_scaled;
    logic signed [20:0]      sum_neg;
    logic [7:0]              delta;
    logic [AMT_W-1:0]        d_full;
    pos      = !amount[AMT_W-1] && (amount != '0);
    below    = (sample < 8'(PIVOT));
    neg_amt  = -amount;
    k        = neg_amt[DIV_W-1:0];
    t        = 9'sd128 - $signed({1'b0, sample});
    prod     = $signed({1'b0, k}) * t;
    x_scaled = NUM_W'(sample * SCALE);
    sum_neg  = $signed({3'b000, x_scaled}) + 21'(prod);
    delta    = below ? (8'(PIVOT) - sample) : (sample - 8'(PIVOT));
    d_full   = AMT_W'(SCALE) - amount;

    s1_next        = '0;
    s1_next.pos    = pos;
    s1_next.below  = below;
    s1_next.alpha  = is_alpha;
    s1_next.sample = sample;
    if (pos) begin
      s1_next.rem = NUM_W'(delta * SCALE);
      // Full contrast leaves a zero divisor; it is taken as one.
      s1_next.div = (amount == AMT_W'(AMOUNT_MAX)) ? DIV_W'(1) : d_full[DIV_W-1:0];
    end else begin
      s1_next.rem = sum_neg[NUM_W-1:0];
      s1_next.div = DIV_W'(SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

  // Stages 2 to 5: divider.
  logic     dv_vld;
  cap_div_t dv;

  cap_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_vld),
    .in_data   (s1),
    .out_valid (dv_vld),
    .out_data  (dv)
  );

  // Stage 6: apply the sign, clamp, and pass alpha.
  logic [7:0] result;

  always_comb begin
    logic [8:0] up;
    logic       rem_nz;
    rem_nz = (dv.rem != '0);
    up     = {1'b0, dv.quo} + 9'(rem_nz);
    if (dv.alpha) begin
      result = dv.sample;
    end else if (!dv.pos) begin
      result = dv.quo;
    end else if (!dv.below) begin
      result = (dv.sat || dv.quo[7]) ? 8'hFF : (8'(PIVOT) + dv.quo);
    end else begin
      // Below the pivot the division rounds toward minus infinity, so the
      // quotient is rounded up before it is subtracted.
      result = (dv.sat || (up >= 9'(PIVOT))) ? 8'h00 : (8'(PIVOT) - up[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adjusted <= result;
    end
  end

endmodule

`default_nettype wire

// ===== tb/contrast_adjust_pixel_tb.sv =====
// ----------------------------------------------------------------------------
// contrast_adjust_pixel_tb
// Self-checking bench for the contrast adjustment pipeline. A short table of
// corner cases comes first, then random pixel components under several
// contrast amounts and flow-control patterns, each scored against a typed-in
// value or an in-bench model of the contrast curve.
// ----------------------------------------------------------------------------
module contrast_adjust_pixel_tb import cap_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT    = 5;
  localparam int SETTLE      = PIPE_LAT + 4;
  localparam int DRAIN_LIMIT = 5000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASE_ITEMS = 105;
  localparam int PRESS_ITEMS = 60;

  typedef struct packed {
    logic [AMT_W-1:0] amount;  // raw register value written before the row
    logic [7:0]       smp;
    logic             alpha;
    logic             known;   // want is typed in; otherwise the model decides
    logic [7:0]       want;
  } dir_row_t;

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // Zero amount leaves components unchanged.
    '{11'h000, 8'd0,   1'b0, 1'b1, 8'd0},
    '{11'h000, 8'd255, 1'b0, 1'b1, 8'd255},
    '{11'h000, 8'd37,  1'b0, 1'b1, 8'd37},
    '{11'h000, 8'd200, 1'b1, 1'b1, 8'd200},
    // Full contrast is a hard threshold at the pivot.
    '{11'h3E8, 8'd0,   1'b0, 1'b1, 8'd0},
    '{11'h3E8, 8'd127, 1'b0, 1'b1, 8'd0},
    '{11'h3E8, 8'd128, 1'b0, 1'b1, 8'd128},
    '{11'h3E8, 8'd129, 1'b0, 1'b1, 8'd255},
    '{11'h3E8, 8'd255, 1'b0, 1'b1, 8'd255},
    '{11'h3E8, 8'd5,   1'b1, 1'b1, 8'd5},
    // Minimum contrast flattens everything onto the pivot.
    '{11'h418, 8'd0,   1'b0, 1'b1, 8'd128},
    '{11'h418, 8'd255, 1'b0, 1'b1, 8'd128},
    '{11'h418, 8'd77,  1'b0, 1'b1, 8'd128},
    '{11'h418, 8'd255, 1'b1, 1'b1, 8'd255},
    // Out-of-range writes saturate: 1023 and 1001 act as 1000,
    // -1024 and -1001 act as -1000.
    '{11'h3FF, 8'd100, 1'b0, 1'b1, 8'd0},
    '{11'h3FF, 8'd200, 1'b0, 1'b1, 8'd255},
    '{11'h400, 8'd3,   1'b0, 1'b1, 8'd128},
    '{11'h3E9, 8'd0,   1'b0, 1'b1, 8'd0},
    '{11'h417, 8'd250, 1'b0, 1'b1, 8'd128},
    // Remaining rows are scored by the model.
    '{11'h3E7, 8'd127, 1'b0, 1'b0, 8'd0},
    '{11'h3E7, 8'd130, 1'b0, 1'b0, 8'd0},
    '{11'h1F4, 8'd64,  1'b0, 1'b0, 8'd0},
    '{11'h1F4, 8'd192, 1'b0, 1'b0, 8'd0},
    '{11'h7FF, 8'd255, 1'b0, 1'b0, 8'd0},
    '{11'h7FF, 8'd0,   1'b0, 1'b0, 8'd0}
  };

  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             cfg_write_en   = 1'b0;
  logic [AMT_W-1:0] cfg_write_data = '0;
  logic             in_valid       = 1'b0;
  logic             in_stall;
  logic [7:0]       sample         = '0;
  logic             is_alpha       = 1'b0;
  logic             out_valid;
  logic             out_stall      = 1'b0;
  logic [7:0]       adjusted;

  int         amount_now;          // model copy of the contrast register
  logic [7:0] adjusted_q[$];       // expected components, oldest first
  int         errors      = 0;
  int         n_items     = 0;
  int         n_alpha     = 0;
  int         n_results   = 0;
  int         n_cfg       = 0;
  int         send_idle_pct = 0;
  int         stall_pct   = 0;
  int         hold_trigger = 0;
  int         hold_seen   = 0;
  int         hold_left   = 0;

  contrast_adjust_pixel i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .is_alpha       (is_alpha),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .adjusted       (adjusted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int sat_amount(logic [AMT_W-1:0] raw);
    int v;
    v = $signed(raw);
    if (v > AMOUNT_MAX) v = AMOUNT_MAX;
    if (v < -AMOUNT_MAX) v = -AMOUNT_MAX;
    return v;
  endfunction

  function automatic logic [7:0] predict_adjusted(logic [7:0] s, logic alpha, int m);
    int x;
    int num;
    int den;
    int v;
    if (alpha) return s;
    x = s;
    if (m <= 0) begin
      num = SCALE * x + (-m) * (PIVOT - x);
      den = SCALE;
    end else begin
      num = SCALE * (x - PIVOT);
      den = (SCALE - m < 1) ? 1 : SCALE - m;
    end
    // Division rounds toward minus infinity; the divisor is always positive.
    v = (num >= 0) ? num / den : -((-num + den - 1) / den);
    if (m > 0) v = v + PIVOT;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Receiver: a requested long hold-off takes priority over random stalls.
  always @(posedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (adjusted_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got adjusted=%0d", $time, adjusted);
        errors++;
      end else begin
        if (adjusted !== adjusted_q[0]) begin
          $display("%0t: adjusted mismatch, expected %0d, got %0d",
                   $time, adjusted_q[0], adjusted);
          errors++;
        end
        void'(adjusted_q.pop_front());
      end
    end
  end

  // Offers one component and returns at the edge where it is accepted.
  task automatic push_sample(logic [7:0] s, logic alpha, logic known, logic [7:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    is_alpha <= alpha;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    adjusted_q.push_back(known ? want : predict_adjusted(s, alpha, amount_now));
    n_items++;
    if (alpha) n_alpha++;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (adjusted_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (adjusted_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived, expected none left, got %0d",
               $time, adjusted_q.size(), adjusted_q.size());
      errors++;
      adjusted_q.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_amount(logic [AMT_W-1:0] raw);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= raw;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    amount_now = sat_amount(raw);
    n_cfg++;
  endtask

  task automatic random_item();
    logic [7:0] s;
    case ($urandom_range(3))
      0: s = 8'($urandom_range(120, 136));
      1: begin
        case ($urandom_range(4))
          0: s = 8'd0;
          1: s = 8'd255;
          2: s = 8'd127;
          3: s = 8'd128;
          default: s = 8'd129;
        endcase
      end
      default: s = 8'($urandom_range(255));
    endcase
    push_sample(s, $urandom_range(7) == 0, 1'b0, 8'd0);
  endtask

  initial begin
    logic [AMT_W-1:0] last_raw;
    logic [AMT_W-1:0] raw;
    int mode;
    amount_now = 0;
    last_raw   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      if (r == 0 || DIR_ROWS[r].amount != last_raw) begin
        write_amount(DIR_ROWS[r].amount);
        last_raw = DIR_ROWS[r].amount;
      end
      push_sample(DIR_ROWS[r].smp, DIR_ROWS[r].alpha, DIR_ROWS[r].known, DIR_ROWS[r].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1:       raw = 11'h3E8;                 // full contrast
        2:       raw = 11'h418;                 // minimum contrast
        4:       raw = 11'h001;
        5:       raw = 11'h7FF;
        3, 6:    raw = 11'($urandom_range(2047));    // whole register range
        default: raw = 11'($urandom_range(2000) - 1000);
      endcase
      write_amount(raw);
      mode = ph % 4;
      send_idle_pct = (mode == 1) ? 75 : (mode == 3) ? 6 : 0;
      stall_pct    <= (mode == 2) ? 75 : (mode == 3) ? 6 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Halfway through one phase the source stops until the pipe is empty.
        if (ph == 5 && i == PHASE_ITEMS / 2) wait_idle();
        random_item();
      end
    end

    // Long output hold-off while the source keeps pushing: the pipe backs up.
    write_amount(11'h3E7);
    send_idle_pct = 0;
    stall_pct    <= 0;
    hold_trigger <= hold_trigger + 1;
    for (int i = 0; i < PRESS_ITEMS; i++) random_item();

    wait_idle();
    $display("Sent %0d items (%0d alpha), scored %0d results across %0d amount writes,",
             n_items, n_alpha, n_results, n_cfg);
    $display("including saturating amounts, both curve extremes and long output back-pressure.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cap_pkg.sv
rtl/core/cap_divider.sv
rtl/core/contrast_adjust_pixel.sv
tb/contrast_adjust_pixel_tb.sv
